// ===== design/key_event_debounce_queue_assert.svh =====
// ---------------------------------------------------------------------------
// Key event debounce queue assertion macros
// Wrappers for the concurrent checks in the top level; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef KEY_EVENT_DEBOUNCE_QUEUE_ASSERT_SVH
`define KEY_EVENT_DEBOUNCE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define KEDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key_event_debounce_queue: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KEDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key_event_debounce_queue: next-cycle check failed");

`else

`define KEDQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define KEDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/kedq_pkg.sv =====
// ---------------------------------------------------------------------------
// Key event debounce queue package
// Shared widths, codes, defaults and the controller command bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kedq_pkg;

   localparam int KEYS_DEFAULT        = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 20;

   localparam int KEY_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam int LEVEL_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] DOWN_TIME_RESET = 8'd2;
   localparam logic [COUNT_W-1:0] HOLD_TIME_RESET = 8'd50;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_TIME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME = 1'b1;

   // Request kinds.
   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Event status codes.
   localparam logic [STATUS_W-1:0] ST_UP   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DOWN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_HOLD = 2'd2;

   // Queue fill level codes.
   localparam logic [LEVEL_W-1:0] LVL_EMPTY  = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_FULL   = 2'd2;

   typedef struct packed {
      logic load;   // capture the request payload
      logic scan;   // process one key counter
      logic pop;    // read the oldest queue entry
   } kedq_cmd_type;

endpackage

`default_nettype wire

// ===== design/kedq_ctrl.sv =====
// ---------------------------------------------------------------------------
// Key event debounce queue controller
// Sequences scan ticks over the key counters and pop reads of the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kedq_ctrl #(
   parameter int KEYS = kedq_pkg::KEYS_DEFAULT,
   parameter int KIW  = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_kind,
   output logic                       busy,
   output logic                       rsp_strobe,
   output kedq_pkg::kedq_cmd_type     cmd,
   output logic [KIW-1:0]             key_idx
);
   import kedq_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_POP_RD  = 2'd2;
   localparam logic [1:0] S_POP_OUT = 2'd3;

   localparam logic [KIW-1:0] LAST_IDX = KIW'(KEYS - 1);

   logic [1:0]     state_ff, state_in;
   logic [KIW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = (req_kind == KIND_POP) ? S_POP_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + KIW'(1);
            end
         end
         S_POP_RD: begin
            cmd.pop  = 1'b1;
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_POP_OUT);
   assign key_idx    = idx_ff;

endmodule

`default_nettype wire

// ===== design/kedq_dp.sv =====
// ---------------------------------------------------------------------------
// Key event debounce queue datapath
// Press counters, threshold checks, event ring buffer and settings registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kedq_dp #(
   parameter int KEYS        = kedq_pkg::KEYS_DEFAULT,
   parameter int QUEUE_DEPTH = kedq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int KIW         = 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire kedq_pkg::kedq_cmd_type              cmd,
   input  wire logic [KIW-1:0]                      key_idx,
   input  wire logic [kedq_pkg::KEY_W-1:0]          req_scan_key,
   input  wire logic                                csr_write,
   input  wire logic [kedq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kedq_pkg::COUNT_W-1:0]        csr_wdata,
   output logic                                     rsp_event_valid,
   output logic [kedq_pkg::KEY_W-1:0]               rsp_event_key,
   output logic [kedq_pkg::STATUS_W-1:0]            rsp_event_status
);
   import kedq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);
   localparam int ENTRY_W = KEY_W + STATUS_W;

   logic [COUNT_W-1:0]  press_ff [KEYS];
   logic [ENTRY_W-1:0]  mem_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                hit_ff;

   logic [COUNT_W-1:0]  down_ff, hold_ff;
   logic [KEY_W-1:0]    scan_key_ff;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;

   logic [KEY_W-1:0]    key_num;
   logic [COUNT_W-1:0]  press_cur, press_next, cnt_inc;
   logic [COUNT_W:0]    down_plus1;
   logic                push_req, push_en, pop_hit;
   logic [STATUS_W-1:0] push_status;
   logic [PTR_W-1:0]    wr_next, rd_next;

   assign key_num    = KEY_W'(key_idx) + KEY_W'(1);
   assign press_cur  = press_ff[key_idx];
   assign cnt_inc    = press_cur + COUNT_W'(1);
   assign down_plus1 = {1'b0, down_ff} + (COUNT_W + 1)'(1);

   // Threshold checks run in a fixed order: down first, then hold, then the
   // fall-back that makes hold events repeat.
   always_comb begin
      push_req    = 1'b0;
      push_status = ST_UP;
      press_next  = press_cur;
      if (scan_key_ff == key_num) begin
         press_next = cnt_inc;
         if (cnt_inc < down_ff) begin
            push_req = 1'b0;
         end else if ({1'b0, cnt_inc} == down_plus1) begin
            push_req    = 1'b1;
            push_status = ST_DOWN;
         end else if (cnt_inc < hold_ff) begin
            push_req = 1'b0;
         end else if (cnt_inc == hold_ff) begin
            push_req    = 1'b1;
            push_status = ST_HOLD;
         end else begin
            press_next = down_plus1[COUNT_W-1:0];
         end
      end else begin
         if (press_cur > down_ff) begin
            push_req    = 1'b1;
            push_status = ST_UP;
         end
         press_next = '0;
      end
   end

   assign push_en = cmd.scan && push_req && (level_ff != LVL_FULL);
   assign pop_hit = cmd.pop && (level_ff != LVL_EMPTY);
   assign wr_next = (wr_ptr_ff == LAST_POS) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next = (rd_ptr_ff == LAST_POS) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_en) begin
         wr_ptr_in = wr_next;
         level_in  = (wr_next == rd_ptr_ff) ? LVL_FULL : LVL_NORMAL;
      end else if (pop_hit) begin
         rd_ptr_in = rd_next;
         level_in  = (rd_next == wr_ptr_ff) ? LVL_EMPTY : LVL_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= LVL_EMPTY;
         down_ff   <= DOWN_TIME_RESET;
         hold_ff   <= HOLD_TIME_RESET;
         for (int i = 0; i < KEYS; i++) begin
            press_ff[i] <= '0;
         end
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
         if (cmd.scan) begin
            press_ff[key_idx] <= press_next;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_DOWN_TIME: down_ff <= csr_wdata;
               CSR_HOLD_TIME: hold_ff <= csr_wdata;
               default:       down_ff <= down_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_key_ff <= req_scan_key;
      end
      if (cmd.pop) begin
         hit_ff <= pop_hit;
      end
   end

   // Event memory: one write port for pushes, one registered read port.
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= {key_num, push_status};
      end
      if (pop_hit) begin
         rd_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign rsp_event_valid  = hit_ff;
   assign rsp_event_key    = hit_ff ? rd_data_ff[ENTRY_W-1:STATUS_W] : '0;
   assign rsp_event_status = hit_ff ? rd_data_ff[STATUS_W-1:0] : ST_UP;

endmodule

`default_nettype wire

// ===== design/key_event_debounce_queue.sv =====
// A scan tick has an accept step, then the controller steps through the key
// counters one by one in ascending order.
// A pop passes through a read state and an output state; its result strobes
// in the cycle after the registered read of the event memory.
// Results cannot be stalled. Synchronous reset clears counters, queue pointers
// and level, and loads the default thresholds; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Key event debounce queue
// Debounces scanned keys with hold repeat and queues up/down/hold events.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_event_debounce_queue #(
   parameter int KEYS        = kedq_pkg::KEYS_DEFAULT,
   parameter int QUEUE_DEPTH = kedq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_kind,
   input  wire logic [kedq_pkg::KEY_W-1:0]          req_scan_key,
   output logic                                     rsp_strobe,
   output logic                                     rsp_event_valid,
   output logic [kedq_pkg::KEY_W-1:0]               rsp_event_key,
   output logic [kedq_pkg::STATUS_W-1:0]            rsp_event_status,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [kedq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kedq_pkg::COUNT_W-1:0]        csr_wdata
);
   import kedq_pkg::*;

`include "key_event_debounce_queue_assert.svh"

   localparam int KIW = (KEYS > 1) ? $clog2(KEYS) : 1;

   kedq_cmd_type   cmd;
   logic [KIW-1:0] key_idx;
   logic           start_ok;
   logic           rsp_empty_fields;

   assign start_ok  = start && !busy;
   assign csr_ready = 1'b1;

   kedq_ctrl #(
      .KEYS (KEYS),
      .KIW  (KIW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ok),
      .req_kind   (req_kind),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .key_idx    (key_idx)
   );

   kedq_dp #(
      .KEYS        (KEYS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KIW         (KIW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .key_idx          (key_idx),
      .req_scan_key     (req_scan_key),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_event_valid  (rsp_event_valid),
      .rsp_event_key    (rsp_event_key),
      .rsp_event_status (rsp_event_status)
   );

   assign rsp_empty_fields = (rsp_event_key == '0) && (rsp_event_status == ST_UP);

   `KEDQ_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `KEDQ_ASSERT_NEXT(a_start_busy, clock, reset, start_ok, busy)
   `KEDQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `KEDQ_ASSERT_SAME(a_empty_zero, clock, reset, rsp_strobe && !rsp_event_valid, rsp_empty_fields)

endmodule

`default_nettype wire

// ===== tb/sv/tb_key_event_debounce_queue.sv =====
// ---------------------------------------------------------------------------
// Key event debounce queue testbench
// Drives scan ticks and pops through the start/busy handshake, predicts every
// popped event with a behavioral copy of the debounce counters and the event
// ring or a fixed directed row, and compares each strobed result field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_key_event_debounce_queue;
   import kedq_pkg::*;

   localparam int NUM_KEYS    = KEYS_DEFAULT;
   localparam int RING_DEPTH  = QUEUE_DEPTH_DEFAULT;
   localparam int SETTLE      = NUM_KEYS + 6;
   localparam int CYCLE_LIMIT = 600000;
   localparam int NUM_ROWS    = 22;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [STATUS_W-1:0] status;
   } key_event_type;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic             fixed;
      key_event_type    ev;
   } stim_row_type;

   localparam key_event_type NO_EVENT = '0;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 req_kind     = KIND_SCAN;
   logic [KEY_W-1:0]     req_scan_key = '0;
   logic                 csr_valid    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_DOWN_TIME;
   logic [COUNT_W-1:0]   csr_wdata    = '0;
   wire                  busy;
   wire                  csr_ready;
   wire                  rsp_strobe;
   wire                  rsp_event_valid;
   wire [KEY_W-1:0]      rsp_event_key;
   wire [STATUS_W-1:0]   rsp_event_status;

   // Predictor state: debounce counters, thresholds and the event ring.
   logic [COUNT_W-1:0]  cfg_down;
   logic [COUNT_W-1:0]  cfg_hold;
   logic [COUNT_W-1:0]  key_count [1:NUM_KEYS];
   logic [KEY_W-1:0]    ring_key [RING_DEPTH];
   logic [STATUS_W-1:0] ring_status [RING_DEPTH];
   int                  ring_rd;
   int                  ring_wr;
   logic [LEVEL_W-1:0]  ring_level;

   key_event_type pending_events [$];
   int            error_count  = 0;
   int            cycle_count  = 0;
   int            stretch_left = 0;
   bit            no_idle      = 1'b0;

   key_event_debounce_queue u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_scan_key     (req_scan_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_event_valid  (rsp_event_valid),
      .rsp_event_key    (rsp_event_key),
      .rsp_event_status (rsp_event_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic ring_push(logic [KEY_W-1:0] key, logic [STATUS_W-1:0] status);
      if (ring_level == LVL_FULL) return;
      ring_key[ring_wr]    = key;
      ring_status[ring_wr] = status;
      ring_wr              = (ring_wr + 1) % RING_DEPTH;
      ring_level           = (ring_wr == ring_rd) ? LVL_FULL : LVL_NORMAL;
   endtask

   task automatic ring_pop(output key_event_type ev);
      if (ring_level == LVL_EMPTY) begin
         ev = NO_EVENT;
         return;
      end
      ev         = '{1'b1, ring_key[ring_rd], ring_status[ring_rd]};
      ring_rd    = (ring_rd + 1) % RING_DEPTH;
      ring_level = (ring_rd == ring_wr) ? LVL_EMPTY : LVL_NORMAL;
   endtask

   task automatic debounce_tick(logic [KEY_W-1:0] scan);
      int down1;
      int v;
      down1 = int'(cfg_down) + 1;
      for (int k = 1; k <= NUM_KEYS; k++) begin
         if (int'(scan) == k) begin
            key_count[k] = key_count[k] + 8'd1;
            v = int'(key_count[k]);
            // Thresholds are checked down first, then hold, then fall-back.
            if (v == down1) begin
               ring_push(KEY_W'(k), ST_DOWN);
            end else if (v >= int'(cfg_down) && v >= int'(cfg_hold)) begin
               if (v == int'(cfg_hold))
                  ring_push(KEY_W'(k), ST_HOLD);
               else
                  key_count[k] = down1[COUNT_W-1:0];
            end
         end else begin
            if (key_count[k] > cfg_down) ring_push(KEY_W'(k), ST_UP);
            key_count[k] = '0;
         end
      end
   endtask

   task automatic send_item(logic kind, logic [KEY_W-1:0] key, logic fixed,
                            key_event_type fixed_ev);
      int gap;
      key_event_type ev;
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(10, 40);
         no_idle      = ($urandom_range(0, 3) == 0);
      end
      stretch_left--;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= kind;
      req_scan_key <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The transfer happened at this edge.
      if (kind == KIND_SCAN) begin
         debounce_tick(key);
      end else begin
         ring_pop(ev);
         pending_events.push_back(fixed ? fixed_ev : ev);
      end
   endtask

   // Leaves the block idle: no request, no result owed, no scan in flight.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_DOWN_TIME)
         cfg_down = value;
      else
         cfg_hold = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly held-key runs sized around the thresholds, with pops mixed in
   // and an occasional random transfer that breaks the run.
   task automatic run_phase(int budget);
      int issued;
      int run_len;
      int lo;
      int hi;
      int dt;
      int ht;
      int pop_pct;
      logic [KEY_W-1:0] held;
      issued  = 0;
      dt      = int'(cfg_down);
      ht      = int'(cfg_hold);
      pop_pct = $urandom_range(15, 45);
      while (issued < budget) begin
         lo = 1;
         hi = 8;
         case ($urandom_range(0, 3))
            0: hi = dt + 3;
            1: begin
               lo = dt;
               hi = dt + 3;
            end
            2: begin
               if (ht > dt + 1) begin
                  lo = ht - 1;
                  hi = ht + 2 * (ht - dt) + 4;
               end else begin
                  hi = dt + 20;
               end
            end
            default: hi = 8;
         endcase
         if (lo < 1) lo = 1;
         if (hi > 320) hi = 320;
         if (hi < lo) hi = lo;
         run_len = $urandom_range(hi, lo);
         if ($urandom_range(0, 9) < 8)
            held = KEY_W'($urandom_range(1, NUM_KEYS));
         else if ($urandom_range(0, 1) == 0)
            held = '0;
         else
            held = KEY_W'($urandom_range(NUM_KEYS + 1, 15));
         for (int i = 0; i < run_len && issued < budget; i++) begin
            if ($urandom_range(0, 99) < pop_pct) begin
               send_item(KIND_POP, KEY_W'($urandom), 1'b0, NO_EVENT);
               issued++;
            end
            if ($urandom_range(0, 99) < 4) begin
               send_item(1'($urandom), KEY_W'($urandom), 1'b0, NO_EVENT);
               issued++;
            end
            send_item(KIND_SCAN, held, 1'b0, NO_EVENT);
            issued++;
         end
      end
   endtask

   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_strobe) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event result: valid %0d key %0d status %0d",
                   rsp_event_valid, rsp_event_key, rsp_event_status);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_valid !== want.valid) begin
               $error("event_valid: expected %0d, got %0d", want.valid, rsp_event_valid);
               error_count++;
            end
            if (rsp_event_key !== want.key) begin
               $error("event_key: expected %0d, got %0d", want.key, rsp_event_key);
               error_count++;
            end
            if (rsp_event_status !== want.status) begin
               $error("event_status: expected %0d, got %0d", want.status, rsp_event_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      stim_row_type       directed_rows [NUM_ROWS];
      logic [COUNT_W-1:0] phase_down [8];
      logic [COUNT_W-1:0] phase_hold [8];
      logic [COUNT_W-1:0] next_down;
      logic [COUNT_W-1:0] next_hold;

      // Reset thresholds: a key needs three ticks for its down event.
      directed_rows = '{
         '{KIND_POP,  4'd0,  1'b1, NO_EVENT},
         '{KIND_SCAN, 4'd0,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd1,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd1,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd1,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd0,  1'b0, NO_EVENT},
         '{KIND_POP,  4'd15, 1'b1, '{1'b1, 4'd1, ST_DOWN}},
         '{KIND_POP,  4'd0,  1'b1, '{1'b1, 4'd1, ST_UP}},
         '{KIND_POP,  4'd0,  1'b1, NO_EVENT},
         '{KIND_SCAN, 4'd15, 1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd5,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd5,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd5,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd6,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd3,  1'b0, NO_EVENT},
         '{KIND_POP,  4'd7,  1'b0, NO_EVENT},
         '{KIND_POP,  4'd8,  1'b0, NO_EVENT},
         '{KIND_POP,  4'd0,  1'b1, NO_EVENT},
         '{KIND_SCAN, 4'd4,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd3,  1'b0, NO_EVENT},
         '{KIND_SCAN, 4'd0,  1'b0, NO_EVENT},
         '{KIND_POP,  4'd0,  1'b1, NO_EVENT}
      };
      // Default, fast repeat, hold below down, both zero, narrow window,
      // window near the counter top, down event past the counter range, zero hold.
      phase_down = '{8'd2,  8'd0, 8'd5, 8'd0, 8'd1, 8'd250, 8'd255, 8'd255};
      phase_hold = '{8'd50, 8'd2, 8'd3, 8'd0, 8'd4, 8'd254, 8'd255, 8'd0};

      cfg_down   = DOWN_TIME_RESET;
      cfg_hold   = HOLD_TIME_RESET;
      ring_rd    = 0;
      ring_wr    = 0;
      ring_level = LVL_EMPTY;
      for (int k = 1; k <= NUM_KEYS; k++) key_count[k] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++)
         send_item(directed_rows[r].kind, directed_rows[r].key,
                   directed_rows[r].fixed, directed_rows[r].ev);
      drain();

      for (int p = 0; p < 11; p++) begin
         if (p < 8) begin
            next_down = phase_down[p];
            next_hold = phase_hold[p];
         end else begin
            next_down = COUNT_W'($urandom_range(0, 12));
            next_hold = COUNT_W'($urandom_range(0, 30));
         end
         write_csr(CSR_DOWN_TIME, next_down);
         write_csr(CSR_HOLD_TIME, next_hold);
         run_phase((next_hold > 100) ? int'(next_hold) + 60 : 65);
         drain();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/kedq_pkg.sv
design/kedq_ctrl.sv
design/kedq_dp.sv
design/key_event_debounce_queue.sv
tb/sv/tb_key_event_debounce_queue.sv
